[rtl/pdf_pkg.sv]
// ----------------------------------------------------------------------------
// pdf_pkg: shared definitions for the padded packet deframer
// Header size, packet mode codes and configuration register map.
// ----------------------------------------------------------------------------
package pdf_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int HEADER_BYTES    = 3;
  localparam int CFG_ADDR_BITS   = 2;

  localparam logic [CFG_ADDR_BITS-1:0] REG_MAGIC_VALUE = 2'd0;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_PASS   = 4'b0010,
    MODE_PADDED = 4'b0100,
    MODE_DROP   = 4'b1000
  } mode_t;

endpackage

[rtl/padded_packet_deframer.sv]
// ----------------------------------------------------------------------------
// padded_packet_deframer: strip a length header and trailing padding
// The result of an accepted input beat is registered and shown in the cycle after.
// Throughput: one beat per cycle; the output register is the only stage and
// takes a new result whenever it is empty or being drained.
// Reset: synchronous active-low rst_n clears the packet state, the output
// valid and the magic value register (magic value resets to zero).
// ----------------------------------------------------------------------------
module padded_packet_deframer #(
  parameter int LENGTH_BITS = pdf_pkg::LENGTH_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: data_byte [7:0], packet_length [23:8]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [23:0]                       in_tdata,
  // out_tdata: out_byte [7:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,
  output logic                              out_tlast,
  // out_tuser: status [0], was_padded [1]
  output logic [1:0]                        out_tuser,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [pdf_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);

  localparam int LB = LENGTH_BITS;

  logic [7:0]           magic_r;
  pdf_pkg::mode_t       mode_r, mode_nxt, mode_cur;
  logic [LB-1:0]        idx_r, idx_nxt;
  logic [7:0]           len_hi_r, len_hi_nxt;
  logic [15:0]          pay_len_r, pay_len_nxt;

  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic                 out_last_r;
  logic                 out_status_r;
  logic                 out_padded_r;

  logic [7:0]           in_byte;
  logic [LB-1:0]        plen;
  logic [LB:0]          idx_inc;
  logic                 pkt_end;
  logic [15:0]          len_w;
  logic [16:0]          len_sum;
  logic [16:0]          pay_lim;
  logic [16:0]          pay_last;
  logic [16:0]          idx_ext;
  logic                 in_acc;

  logic                 res_v;
  logic [7:0]           res_byte;
  logic                 res_last;
  logic                 res_status;
  logic                 res_padded;

  assign in_byte = in_tdata[7:0];
  assign plen    = in_tdata[8 +: LB];
  assign in_acc  = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;

  assign idx_inc  = {1'b0, idx_r} + {{LB{1'b0}}, 1'b1};
  assign pkt_end  = idx_inc >= {1'b0, plen};
  assign len_w    = {len_hi_r, in_byte};
  assign len_sum  = {1'b0, len_w} + 17'(pdf_pkg::HEADER_BYTES);
  assign idx_ext  = 17'(idx_r);
  assign pay_lim  = {1'b0, pay_len_r} + 17'(pdf_pkg::HEADER_BYTES);
  assign pay_last = {1'b0, pay_len_r} + 17'(pdf_pkg::HEADER_BYTES - 1);

  always_comb begin
    if (mode_r == pdf_pkg::MODE_IDLE) begin
      if (17'(plen) < 17'(pdf_pkg::HEADER_BYTES) || in_byte != magic_r) begin
        mode_cur = pdf_pkg::MODE_PASS;
      end else begin
        mode_cur = pdf_pkg::MODE_PADDED;
      end
    end else begin
      mode_cur = mode_r;
    end
  end

  always_comb begin
    mode_nxt    = mode_cur;
    len_hi_nxt  = len_hi_r;
    pay_len_nxt = pay_len_r;
    res_v       = 1'b0;
    res_byte    = in_byte;
    res_last    = pkt_end;
    res_status  = 1'b0;
    res_padded  = 1'b0;
    case (mode_cur)
      pdf_pkg::MODE_PASS: begin
        res_v = 1'b1;
      end
      pdf_pkg::MODE_PADDED: begin
        res_padded = 1'b1;
        if (idx_r == LB'(1)) begin
          len_hi_nxt = in_byte;
        end else if (idx_r == LB'(2)) begin
          if (len_w == 16'd0 || len_sum > 17'(plen)) begin
            res_v      = 1'b1;
            res_byte   = 8'd0;
            res_last   = 1'b1;
            res_status = 1'b1;
            mode_nxt   = pdf_pkg::MODE_DROP;
          end else begin
            pay_len_nxt = len_w;
          end
        end else if (idx_ext >= 17'(pdf_pkg::HEADER_BYTES) && idx_ext < pay_lim) begin
          res_v    = 1'b1;
          res_last = (idx_ext == pay_last) || pkt_end;
        end
      end
      pdf_pkg::MODE_DROP: begin
        res_v = 1'b0;
      end
      default: begin
        res_v = 1'b0;
      end
    endcase
    if (pkt_end) begin
      mode_nxt = pdf_pkg::MODE_IDLE;
      idx_nxt  = '0;
    end else begin
      idx_nxt  = idx_inc[LB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= pdf_pkg::MODE_IDLE;
      idx_r     <= '0;
      len_hi_r  <= '0;
      pay_len_r <= '0;
    end else if (in_acc) begin
      mode_r    <= mode_nxt;
      idx_r     <= idx_nxt;
      len_hi_r  <= len_hi_nxt;
      pay_len_r <= pay_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= res_v;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_v) begin
      out_byte_r   <= res_byte;
      out_last_r   <= res_last;
      out_status_r <= res_status;
      out_padded_r <= res_padded;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_padded_r, out_status_r};

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == pdf_pkg::REG_MAGIC_VALUE) begin
      magic_r <= cfg_pwdata[7:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == pdf_pkg::REG_MAGIC_VALUE) ? {24'd0, magic_r} : 32'd0;

  // error beats are zero-data, last, padded
  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && out_tdata == 8'd0 && out_tuser[1])
    else $error("error beat malformed");

  // input stalls only behind a held result
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without pending result");

  // payload phase always has an accepted nonzero length
  a_paylen: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == pdf_pkg::MODE_PADDED && idx_ext >= 17'(pdf_pkg::HEADER_BYTES)
      |-> pay_len_r != 16'd0)
    else $error("payload phase with zero length");

  // a drop-mode beat never produces a result
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && mode_r == pdf_pkg::MODE_DROP |=> !out_tvalid)
    else $error("result produced while dropping");

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for padded_packet_deframer
// Streams packets one byte per beat (passthrough, padded, bad length, short,
// truncated and length-changing packets) under random sender gaps and
// receiver stalls. A built-in deframer predicts each result beat, and every
// output beat is checked field by field against the oldest prediction. The
// magic value register is written and read back between phases.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       err;
    logic       padded;
  } deframed_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [pdf_pkg::CFG_ADDR_BITS-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  padded_packet_deframer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // deframer model state
  logic [7:0]      magic = 8'h00;
  logic [15:0]     byte_pos = '0;
  pdf_pkg::mode_t  pkt_mode = pdf_pkg::MODE_IDLE;
  logic [7:0]      len_hi = '0;
  logic [15:0]     payload_len = '0;

  deframed_t   expected_bytes[$];
  int          mismatches = 0;
  int          beats_sent = 0;
  int          burst_left = 0;
  int          rx_mode = 0;
  int          rx_left = 0;
  int          rx_period = 2;
  logic [7:0]  pkt_data[$];
  logic [15:0] pkt_len[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bit deframe_byte(input logic [7:0] data, input logic [15:0] plen,
                                      output deframed_t res);
    logic [15:0] orig_len;
    bit          ends;
    bit          hit;
    ends = (byte_pos + 1) >= plen;
    hit  = 1'b0;
    res  = '0;
    if (pkt_mode == pdf_pkg::MODE_IDLE) begin
      if (plen < pdf_pkg::HEADER_BYTES || data != magic) pkt_mode = pdf_pkg::MODE_PASS;
      else pkt_mode = pdf_pkg::MODE_PADDED;
    end
    if (pkt_mode == pdf_pkg::MODE_PASS) begin
      res.value = data;
      res.last  = ends;
      hit       = 1'b1;
    end else if (pkt_mode == pdf_pkg::MODE_PADDED) begin
      if (byte_pos == 1) begin
        len_hi = data;
      end else if (byte_pos == 2) begin
        orig_len = {len_hi, data};
        if (orig_len == 0 || orig_len + pdf_pkg::HEADER_BYTES > plen) begin
          res.last   = 1'b1;
          res.err    = 1'b1;
          res.padded = 1'b1;
          hit        = 1'b1;
          pkt_mode   = pdf_pkg::MODE_DROP;
        end else begin
          payload_len = orig_len;
        end
      end else if (byte_pos >= pdf_pkg::HEADER_BYTES &&
                   byte_pos < payload_len + pdf_pkg::HEADER_BYTES) begin
        res.value  = data;
        res.last   = (byte_pos == payload_len + pdf_pkg::HEADER_BYTES - 1) || ends;
        res.padded = 1'b1;
        hit        = 1'b1;
      end
    end
    if (ends) begin
      pkt_mode = pdf_pkg::MODE_IDLE;
      byte_pos = '0;
    end else begin
      byte_pos = byte_pos + 16'd1;
    end
    return hit;
  endfunction

  function automatic void note_mismatch(string what, deframed_t want, deframed_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t mismatch (%s): expected byte=%02h last=%0b err=%0b padded=%0b,",
                " got byte=%02h last=%0b err=%0b padded=%0b"},
               $time, what, want.value, want.last, want.err, want.padded,
               got.value, got.last, got.err, got.padded);
  endfunction

  always @(posedge clk) begin : monitor
    deframed_t want;
    deframed_t got;
    if (rst_n && in_tvalid && in_tready) begin
      if (deframe_byte(in_tdata[7:0], in_tdata[23:8], want)) expected_bytes.push_back(want);
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata, out_tlast, out_tuser[0], out_tuser[1]};
      if (expected_bytes.size() == 0) begin
        note_mismatch("unexpected beat", '0, got);
      end else begin
        want = expected_bytes.pop_front();
        if (got.value !== want.value || got.last !== want.last ||
            got.err !== want.err || got.padded !== want.padded)
          note_mismatch("field", want, got);
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode   = $urandom_range(0, 3);
      rx_left   = $urandom_range(8, 80);
      rx_period = $urandom_range(2, 5);
    end
    rx_left--;
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (rx_left % rx_period) != 0;
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_beat(input logic [7:0] data, input logic [15:0] plen);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {plen, data};
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  task automatic send_packet();
    foreach (pkt_data[i]) send_beat(pkt_data[i], pkt_len[i]);
    pkt_data.delete();
    pkt_len.delete();
  endtask

  task automatic add_byte(input logic [7:0] data, input logic [15:0] plen);
    pkt_data.push_back(data);
    pkt_len.push_back(plen);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_read_check(input logic [7:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= pdf_pkg::REG_MAGIC_VALUE;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {24'h0, value}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch (readback): expected %08h, got %08h", $time, {24'h0, value},
                 cfg_prdata);
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_magic(input logic [7:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= pdf_pkg::REG_MAGIC_VALUE;
    cfg_pwdata  <= {24'h0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    magic = value;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_read_check(value);
  endtask

  // magic is zero out of reset
  task automatic test_passthrough();
    add_byte(8'h5A, 16'd2); add_byte(8'hFF, 16'd2);
    add_byte(8'h00, 16'd0);
    add_byte(8'h00, 16'd2); add_byte(8'h7F, 16'd2);
    send_packet();
    wait_idle();
  endtask

  task automatic test_padded();
    add_byte(8'hFF, 16'd6); add_byte(8'h00, 16'd6); add_byte(8'h02, 16'd6);
    add_byte(8'hAA, 16'd6); add_byte(8'h55, 16'd6); add_byte(8'hC3, 16'd6);
    add_byte(8'hFE, 16'd3); add_byte(8'h01, 16'd3); add_byte(8'h80, 16'd3);
    send_packet();
    wait_idle();
  endtask

  task automatic test_bad_length();
    add_byte(8'hFF, 16'd3); add_byte(8'h00, 16'd3); add_byte(8'h00, 16'd3);
    add_byte(8'hFF, 16'd4); add_byte(8'h00, 16'd4); add_byte(8'h05, 16'd4);
    add_byte(8'h11, 16'd4);
    send_packet();
    wait_idle();
  endtask

  task automatic test_length_change();
    add_byte(8'hFF, 16'hFFFF); add_byte(8'h00, 16'hFFFF); add_byte(8'h03, 16'hFFFF);
    add_byte(8'h01, 16'hFFFF); add_byte(8'h02, 16'd5);
    add_byte(8'h10, 16'hFFFF); add_byte(8'h20, 16'd1);
    send_packet();
    wait_idle();
  endtask

  task automatic random_packet();
    int          kind;
    int          plen;
    int          len;
    int          pad;
    int          end_at;
    logic [15:0] orig;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      orig   = ($urandom_range(0, 99) == 0) ? 16'($urandom_range(256, 300))
                                            : 16'($urandom_range(1, 12));
      pad    = $urandom_range(0, 4);
      plen   = pdf_pkg::HEADER_BYTES + orig + pad;
      end_at = plen - 1;
      if ($urandom_range(0, 9) == 0 && plen > 4) end_at = $urandom_range(3, plen - 2);
      for (int i = 0; i <= end_at; i++) begin
        logic [7:0] data;
        data = (i == 0) ? magic : (i == 1) ? orig[15:8] : (i == 2) ? orig[7:0]
                                                            : 8'($urandom);
        add_byte(data, (i == end_at) ? 16'($urandom_range(0, i + 1)) : 16'(plen));
        if (i == end_at && end_at != plen - 1) pkt_len[i] = 16'(i + 1);
        if (i == end_at && end_at == plen - 1) pkt_len[i] = 16'(plen);
      end
    end else if (kind < 70) begin
      plen = $urandom_range(3, 10);
      orig = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(plen - 2, 65535));
      add_byte(magic, 16'(plen)); add_byte(orig[15:8], 16'(plen));
      add_byte(orig[7:0], 16'(plen));
      for (int i = 3; i < plen; i++) add_byte(8'($urandom), 16'(plen));
    end else if (kind < 80) begin
      plen = $urandom_range(1, 2);
      add_byte(magic, 16'(plen));
      if (plen == 2) add_byte(8'($urandom), 16'(plen));
    end else begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        if (i == len - 1) add_byte(8'($urandom), 16'($urandom_range(0, i + 1)));
        else add_byte(8'($urandom), 16'($urandom_range(i + 2, 65535)));
      end
    end
    send_packet();
  endtask

  task automatic test_random(input int beats);
    int target;
    target = beats_sent + beats;
    while (beats_sent < target) random_packet();
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    cfg_read_check(8'h00);
    test_passthrough();
    set_magic(8'hFF);
    test_padded();
    test_bad_length();
    test_length_change();
    set_magic(8'($urandom_range(1, 254)));
    test_random(280);
    set_magic(8'h00);
    test_random(280);
    set_magic(8'hFF);
    test_random(280);
    set_magic(8'hA5);
    test_random(280);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[padded_packet_deframer.f]
rtl/pdf_pkg.sv
rtl/padded_packet_deframer.sv
sim/tb.sv
